// ----- sv/disk_overlap_rejection_placer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Disk placer assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DISK_OVERLAP_REJECTION_PLACER_CORE_DEFINES_SVH
`define DISK_OVERLAP_REJECTION_PLACER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DORP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DORP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DORP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DORP_ASSERT(lbl, clk, rst_n, prop, msg)
`define DORP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DORP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/dorp_pkg.sv -----
// ----------------------------------------------------------------------------
// Disk placer package
// Field widths, codes, register defaults and shared types.
// ----------------------------------------------------------------------------
package dorp_pkg;

    localparam int DEF_MAX_DISKS  = 256;
    localparam int DEF_COORD_BITS = 16;

    localparam int RADIUS_W    = 16;
    localparam int STRENGTH_W  = 16;
    localparam int SPACING_W   = 8;
    localparam int TRIES_W     = 16;
    localparam int LIST_W      = 9;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // spacing is Q4.4, so its square carries eight fraction bits
    localparam int FRAC_BITS = 4;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd16;
    localparam logic [TRIES_W-1:0]   TRIES_RESET   = 16'd100;
    localparam logic [LIST_W-1:0]    LIST_RESET    = 9'd256;
    localparam logic [TRIES_W-1:0]   RUN_MAX       = 16'hFFFF;

    typedef enum logic [0:0] {
        OP_PLACE = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT  = 3'd0,
        ST_REJECT  = 3'd1,
        ST_EXHAUST = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPACING     = 2'd0,
        CFG_MAX_TRIES   = 2'd1,
        CFG_LIST_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } unit_status_t;

endpackage

// ----- sv/dorp_cand_if.sv -----
// ----------------------------------------------------------------------------
// Candidate channel
// Valid/ready channel carrying one place or clear word.
// ----------------------------------------------------------------------------
interface dorp_cand_if #(
    parameter int COORD_BITS = dorp_pkg::DEF_COORD_BITS
);
    import dorp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [0:0]                   operation;
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
    logic [RADIUS_W-1:0]          cand_radius;
    logic signed [STRENGTH_W-1:0] cand_strength;

    modport source (
        output valid, operation, cand_x, cand_y, cand_radius, cand_strength,
        input  ready
    );

    modport sink (
        input  valid, operation, cand_x, cand_y, cand_radius, cand_strength,
        output ready
    );
endinterface

// ----- sv/dorp_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one status word per item.
// ----------------------------------------------------------------------------
interface dorp_result_if;
    import dorp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot_index;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   list_done;

    modport source (
        output valid, status, slot_index, entry_count, list_done,
        input  ready
    );

    modport sink (
        input  valid, status, slot_index, entry_count, list_done,
        output ready
    );
endinterface

// ----- sv/dorp_disk_mem.sv -----
// ----------------------------------------------------------------------------
// Disk table memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module dorp_disk_mem #(
    parameter int DEPTH  = dorp_pkg::DEF_MAX_DISKS,
    parameter int WORD_W = 2 * dorp_pkg::DEF_COORD_BITS + dorp_pkg::RADIUS_W
                           + dorp_pkg::STRENGTH_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WORD_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WORD_W-1:0]        rdata
);
    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- sv/dorp_overlap_unit.sv -----
// ----------------------------------------------------------------------------
// Overlap compare unit
// Four-stage pipeline: 256*(dx^2+dy^2) < (s*(r1+r2))^2, one disk per cycle.
// ----------------------------------------------------------------------------
module dorp_overlap_unit #(
    parameter int COORD_BITS = dorp_pkg::DEF_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  cand_x,
    input  logic signed [COORD_BITS-1:0]  cand_y,
    input  logic [dorp_pkg::RADIUS_W-1:0] cand_radius,
    input  logic signed [COORD_BITS-1:0]  disk_x,
    input  logic signed [COORD_BITS-1:0]  disk_y,
    input  logic [dorp_pkg::RADIUS_W-1:0] disk_radius,
    input  logic [dorp_pkg::SPACING_W-1:0] spacing,
    output dorp_pkg::unit_status_t        status
);
    import dorp_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int D2_W   = SQ_W + 1;
    localparam int RS_W   = RADIUS_W + 1;
    localparam int SRS_W  = RS_W + SPACING_W;
    localparam int SRS2_W = 2 * SRS_W;
    localparam int LHS_W  = D2_W + 2 * FRAC_BITS;
    localparam int CMP_W  = (LHS_W > SRS2_W) ? LHS_W : SRS2_W;
    localparam int STAGES = 4;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[COORD_BITS-1:0];
    endfunction

    logic [STAGES-1:0]     v_reg;
    logic [COORD_BITS-1:0] dxa_reg;
    logic [COORD_BITS-1:0] dya_reg;
    logic [RS_W-1:0]       rs_reg;
    logic [SQ_W-1:0]       dx2_reg;
    logic [SQ_W-1:0]       dy2_reg;
    logic [SRS_W-1:0]      srs_reg;
    logic [D2_W-1:0]       d2_reg;
    logic [SRS2_W-1:0]     srs2_reg;
    logic                  hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dxa_reg  <= abs_diff(cand_x, disk_x);
        dya_reg  <= abs_diff(cand_y, disk_y);
        rs_reg   <= RS_W'(cand_radius) + RS_W'(disk_radius);
        dx2_reg  <= SQ_W'(dxa_reg) * SQ_W'(dxa_reg);
        dy2_reg  <= SQ_W'(dya_reg) * SQ_W'(dya_reg);
        srs_reg  <= SRS_W'(rs_reg) * SRS_W'(spacing);
        d2_reg   <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
        srs2_reg <= SRS2_W'(srs_reg) * SRS2_W'(srs_reg);
        hit_reg  <= CMP_W'({d2_reg, {(2 * FRAC_BITS){1'b0}}}) < CMP_W'(srs2_reg);
    end

    assign status.hit_valid = v_reg[STAGES-1];
    assign status.hit       = hit_reg;
    assign status.busy      = in_valid | (|v_reg);
endmodule

// ----- sv/disk_overlap_rejection_placer_core.sv -----
// ----------------------------------------------------------------------------
// Disk overlap rejection placer
// Candidate disk placement against a table of stored disks.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. A clear word, or a
// place word on a full table, goes from idle straight to the result load. A
// place word on an empty table passes through the decide state to the result
// load. Any other place word first scans the table: the disk table has one
// read port, so the stored disks stream one per cycle through a four-stage
// compare unit, followed by a drain of the pipeline, the decide state and the
// result load. The result load waits for as long as the output register still
// holds an earlier result that has not been taken. The input is taken again as
// soon as the result sits in the output register, even while that result
// still waits to be taken. No clearing pass is needed after reset; only
// entries below the fill count are ever read.
`include "disk_overlap_rejection_placer_core_defines.svh"

module disk_overlap_rejection_placer_core #(
    parameter int MAX_DISKS  = dorp_pkg::DEF_MAX_DISKS,
    parameter int COORD_BITS = dorp_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dorp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dorp_pkg::CFG_DATA_W-1:0] cfg_data,
    dorp_cand_if.sink                       cand,
    dorp_result_if.source                   result
);
    import dorp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DISKS + 1);
    localparam int IDX_W  = $clog2(MAX_DISKS);
    localparam int WORD_W = 2 * COORD_BITS + RADIUS_W + STRENGTH_W;
    localparam int LEN_W  = (CNT_W > LIST_W) ? CNT_W : LIST_W;

    state_t                state_reg, state_next;
    logic [SPACING_W-1:0]  spacing_reg;
    logic [TRIES_W-1:0]    tries_reg;
    logic [LIST_W-1:0]     list_len_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TRIES_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  conflict_reg, conflict_next;
    logic                  rd_pend_reg;
    status_t               res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [RADIUS_W-1:0]   cr_reg;
    logic [STRENGTH_W-1:0] cs_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                  out_done_reg;

    logic                  accept;
    logic                  load;
    logic                  mem_we;
    logic                  mem_re;
    logic [WORD_W-1:0]     rd_word;
    logic [TRIES_W-1:0]    run_inc;
    unit_status_t          ust;

    assign cand.ready = (state_reg == S_IDLE);
    assign accept     = cand.valid && cand.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg  <= SPACING_RESET;
            tries_reg    <= TRIES_RESET;
            list_len_reg <= LIST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPACING:     spacing_reg  <= cfg_data[SPACING_W-1:0];
                CFG_MAX_TRIES:   tries_reg    <= cfg_data[TRIES_W-1:0];
                CFG_LIST_LENGTH: list_len_reg <= cfg_data[LIST_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            run_reg       <= '0;
            scan_reg      <= '0;
            conflict_reg  <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            scan_reg      <= scan_next;
            conflict_reg  <= conflict_next;
            rd_pend_reg   <= mem_re;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (accept)
        begin
            cx_reg <= cand.cand_x;
            cy_reg <= cand.cand_y;
            cr_reg <= cand.cand_radius;
            cs_reg <= cand.cand_strength;
        end
        if (load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
            out_done_reg   <= LEN_W'(count_reg) >= LEN_W'(list_len_reg);
        end
    end

    assign run_inc = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        run_next        = run_reg;
        scan_next       = scan_reg;
        conflict_next   = conflict_reg | (ust.hit_valid & ust.hit);
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        load            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cand.valid)
                begin
                    conflict_next = 1'b0;
                    scan_next     = '0;
                    res_slot_next = '0;
                    if (op_t'(cand.operation) == OP_CLEAR)
                    begin
                        count_next      = '0;
                        run_next        = '0;
                        res_status_next = ST_CLEARED;
                        state_next      = S_RESULT;
                    end
                    else if (count_reg == CNT_W'(MAX_DISKS))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue one table read per cycle
                mem_re    = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (CNT_W'(scan_reg + 1'b1) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // hold until the last compare has landed in conflict_reg
                if (!rd_pend_reg && !ust.busy)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (conflict_reg)
                begin
                    res_slot_next = '0;
                    if (run_inc >= tries_reg)
                    begin
                        run_next        = '0;
                        res_status_next = ST_EXHAUST;
                    end
                    else
                    begin
                        run_next        = run_inc;
                        res_status_next = ST_REJECT;
                    end
                end
                else
                begin
                    mem_we          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    run_next        = '0;
                    res_status_next = ST_ACCEPT;
                    res_slot_next   = SLOT_W'(count_reg);
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    dorp_disk_mem #(
        .DEPTH  (MAX_DISKS),
        .WORD_W (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({cx_reg, cy_reg, cr_reg, cs_reg}),
        .re    (mem_re),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    dorp_overlap_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rd_pend_reg),
        .cand_x      (cx_reg),
        .cand_y      (cy_reg),
        .cand_radius (cr_reg),
        .disk_x      (rd_word[WORD_W-1 -: COORD_BITS]),
        .disk_y      (rd_word[WORD_W-1-COORD_BITS -: COORD_BITS]),
        .disk_radius (rd_word[STRENGTH_W +: RADIUS_W]),
        .spacing     (spacing_reg),
        .status      (ust)
    );

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.slot_index  = out_slot_reg;
    assign result.entry_count = out_count_reg;
    assign result.list_done   = out_done_reg;

    `DORP_ASSERT_IMPL(a_write_in_range, clk, rst_n, mem_we, count_reg < CNT_W'(MAX_DISKS), "table write past the last slot")
    `DORP_ASSERT_IMPL(a_hit_in_scan, clk, rst_n, ust.hit_valid, (state_reg == S_SCAN) || (state_reg == S_DRAIN), "compare result outside a scan")
    `DORP_ASSERT_IMPL(a_idle_drained, clk, rst_n, cand.ready, !ust.busy && !rd_pend_reg, "ready while compares are in flight")
    `DORP_ASSERT_NEXT(a_accept_counts, clk, rst_n, (state_reg == S_DECIDE) && !conflict_reg, count_reg == $past(count_reg) + 1'b1, "accepted disk did not advance the count")
endmodule
